### design/clnw_pkg.sv
package clnw_pkg;

    // Operation codes carried by op
    localparam logic [1:0] OP_CMD  = 2'd0;
    localparam logic [1:0] OP_DATA = 2'd1;
    localparam logic [1:0] OP_INT  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [7:0] DIGIT_BASE = 8'd48;
    localparam logic [7:0] MINUS_CHAR = 8'd45;
    localparam logic [3:0] TOP_PLACE  = 4'd9;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_DIGIT   = 4'b0010,
        S_SEND_HI = 4'b0100,
        S_SEND_LO = 4'b1000
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic digit;
        logic advance;
        logic emit_hi;
        logic emit_lo;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic in_ignore;
        logic in_direct;
        logic digit_done;
        logic final_char;
    } status_t;

    // Decimal place weights, ones place at index 0
    function automatic logic [31:0] pow10(input logic [3:0] place);
        logic [31:0] w;
        begin
            unique case (place)
                4'd0:    w = 32'd1;
                4'd1:    w = 32'd10;
                4'd2:    w = 32'd100;
                4'd3:    w = 32'd1000;
                4'd4:    w = 32'd10000;
                4'd5:    w = 32'd100000;
                4'd6:    w = 32'd1000000;
                4'd7:    w = 32'd10000000;
                4'd8:    w = 32'd100000000;
                4'd9:    w = 32'd1000000000;
                default: w = 32'd1;
            endcase
            return w;
        end
    endfunction

endpackage

### design/clnw_ctrl.sv
module clnw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  clnw_pkg::status_t st,
    output clnw_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              strobe
);
    import clnw_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Pick the next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !st.in_ignore)
                    state_next = st.in_direct ? S_SEND_HI : S_DIGIT;
            end
            S_DIGIT:
            begin
                if (st.digit_done)
                    state_next = S_SEND_HI;
            end
            S_SEND_HI:
                state_next = S_SEND_LO;
            S_SEND_LO:
                state_next = st.final_char ? S_IDLE : S_DIGIT;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd.load    = (state_reg == S_IDLE) && start;
        cmd.digit   = (state_reg == S_DIGIT);
        cmd.advance = (state_reg == S_SEND_LO) && !st.final_char;
        cmd.emit_hi = (state_reg == S_SEND_HI);
        cmd.emit_lo = (state_reg == S_SEND_LO);
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = (state_reg == S_SEND_HI) || (state_reg == S_SEND_LO);

endmodule

### design/clnw_dp.sv
module clnw_dp (
    input  logic              clk,
    input  logic [1:0]        op,
    input  logic [7:0]        byte_value,
    input  logic signed [31:0] number,
    input  clnw_pkg::cmd_t    cmd,
    output clnw_pkg::status_t st,
    output logic [3:0]        nibble,
    output logic              reg_select,
    output logic              last
);
    import clnw_pkg::*;

    logic [31:0] mag_reg;
    logic [3:0]  place_reg;
    logic [3:0]  dig_reg;
    logic        started_reg;
    logic [7:0]  char_reg;
    logic        rs_reg;
    logic        final_reg;

    logic [31:0] raw;
    logic        is_zero;
    logic [31:0] weight;
    logic        ge;

    assign raw     = $unsigned(number);
    assign is_zero = (raw == 32'd0);
    assign weight  = pow10(place_reg);
    assign ge      = (mag_reg >= weight);

    // Report decisions to the controller
    always_comb
    begin
        st.in_ignore  = (op == OP_NONE);
        st.in_direct  = (op != OP_INT) || is_zero || raw[31];
        st.digit_done = !ge && ((dig_reg != 4'd0) || started_reg);
        st.final_char = final_reg;
    end

    // Load a request, peel digits by subtraction, step to the next place
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg     <= raw[31] ? (32'd0 - raw) : raw;
            place_reg   <= TOP_PLACE;
            dig_reg     <= 4'd0;
            started_reg <= 1'b0;
            rs_reg      <= (op != OP_CMD);
            final_reg   <= (op != OP_INT) || is_zero;
            if (op != OP_INT)
                char_reg <= byte_value;
            else if (is_zero)
                char_reg <= DIGIT_BASE;
            else
                char_reg <= MINUS_CHAR;
        end
        else if (cmd.digit)
        begin
            if (ge)
            begin
                mag_reg <= mag_reg - weight;
                dig_reg <= dig_reg + 4'd1;
            end
            else if ((dig_reg != 4'd0) || started_reg)
            begin
                char_reg    <= DIGIT_BASE + {4'd0, dig_reg};
                final_reg   <= (place_reg == 4'd0);
                started_reg <= 1'b1;
            end
            else
            begin
                // drop a leading zero
                place_reg <= place_reg - 4'd1;
            end
        end
        else if (cmd.advance)
        begin
            // after the minus sign the top place is still pending
            if (started_reg)
            begin
                place_reg <= place_reg - 4'd1;
                dig_reg   <= 4'd0;
            end
        end
    end

    // Present the current nibble
    assign nibble     = cmd.emit_hi ? char_reg[7:4] : char_reg[3:0];
    assign reg_select = rs_reg;
    assign last       = cmd.emit_lo && final_reg;

endmodule

### design/char_lcd_nibble_writer.sv
// Channel   Handshake                 Fields
// request   start, accepted when !busy op, byte_value, number
// result    strobe, no stall           nibble, reg_select, last
//
// A command or data byte is accepted, then its high nibble and its low nibble are strobed.
// An integer goes out a character at a time: a minus sign first if it is negative, then
// each digit, found by repeated compare/subtract against its place weight, as high and
// low nibbles; leading zeros are skipped one place at a time. The pace is set by
// the single 32-bit compare/subtract unit that peels digits against powers of ten.
// Reset returns the controller to idle; busy is low after reset.
// The receiver cannot stall; op 3 is taken and produces nothing.
module char_lcd_nibble_writer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [7:0]         byte_value,
    input  logic signed [31:0] number,
    output logic               strobe,
    output logic [3:0]         nibble,
    output logic               reg_select,
    output logic               last
);
    import clnw_pkg::*;

    cmd_t    cmd;
    status_t st;

    clnw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .st     (st),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (strobe)
    );

    clnw_dp u_dp (
        .clk        (clk),
        .op         (op),
        .byte_value (byte_value),
        .number     (number),
        .cmd        (cmd),
        .st         (st),
        .nibble     (nibble),
        .reg_select (reg_select),
        .last       (last)
    );

endmodule

### design/clnw_checker.sv
module clnw_checker (
    input logic clk,
    input logic rst_n,
    input logic busy,
    input logic strobe,
    input logic last
);

    // Last only marks a strobed transfer
    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe)
        else $error("last without strobe");

    // No transfer while idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !strobe)
        else $error("strobe while idle");

    // Final transfer frees the block
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !busy)
        else $error("busy after last transfer");

    // Nibbles come in pairs
    a_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !$past(strobe)) |=> strobe)
        else $error("high nibble without low nibble");

endmodule

bind char_lcd_nibble_writer clnw_checker u_clnw_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .busy   (busy),
    .strobe (strobe),
    .last   (last)
);
